/* src/tlvf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvf_pkg: shared types and constants of the tlv packet framer
// result and job records, framer modes, byte kinds and the header rescan helper
// ----------------------------------------------------------------------------
package tlvf_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'h7f;
  localparam logic [7:0]  TYPE_LOW_MAX  = 8'h04;
  localparam logic [7:0]  TYPE_HIGH_MIN = 8'hfd;
  localparam logic [16:0] MAX_PKT_RESET = 17'd4096;
  localparam logic [16:0] HDR_BYTES     = 17'd4;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_BODY   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_RAW     = 3'd0,
    KIND_REJECT  = 3'd1,
    KIND_PACKET  = 3'd2,
    KIND_FLUSHED = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       first;
    logic       last;
  } res_t;

  // all results caused by one item
  typedef struct packed {
    logic [1:0]     last_idx;
    res_t [3:0]     res;
  } job_t;

  // outcome of scanning the three bytes behind a rejected sync
  typedef struct packed {
    logic            hdr;
    logic [1:0]      hold_cnt;
    logic [2:0][7:0] hold;
    logic [1:0]      n_raw;
  } scan_t;

  function automatic res_t mk_res(logic [7:0] data, kind_t kind, logic first,
                                  logic last);
    res_t r;
    r.data  = data;
    r.kind  = kind;
    r.first = first;
    r.last  = last;
    return r;
  endfunction

  // bytes ahead of the first sync go out raw, the rest are held as a header
  function automatic scan_t tlvf_rescan(logic [2:0][7:0] rest);
    scan_t s;
    s.hdr      = 1'b0;
    s.hold_cnt = 2'd0;
    s.hold     = '0;
    s.n_raw    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (s.hdr) begin
        s.hold[s.hold_cnt] = rest[i];
        s.hold_cnt         = s.hold_cnt + 2'd1;
      end else if (rest[i] == SYNC_BYTE) begin
        s.hdr      = 1'b1;
        s.hold[0]  = rest[i];
        s.hold_cnt = 2'd1;
      end else begin
        s.n_raw = s.n_raw + 2'd1;
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/tlvf_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvf channel interfaces
// valid/ready channels for stream items, results and the limit register
// ----------------------------------------------------------------------------
interface tlvf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;

  modport source (output valid, output operation, output in_byte, input ready);
  modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface tlvf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic       packet_first;
  logic       packet_last;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_kind,
                  output packet_first, output packet_last, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_kind,
                  input packet_first, input packet_last, input last_of_run,
                  output ready);
endinterface

interface tlvf_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] max_packet_bytes;

  modport source (output valid, output max_packet_bytes, input ready);
  modport sink   (input valid, input max_packet_bytes, output ready);
endinterface
`default_nettype wire

/* src/tlv_packet_framer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_packet_framer_unit: tlv packet framer
// finds sync-led tlv packets in a byte stream and tags every byte by its kind
// ----------------------------------------------------------------------------
// The framer takes one stream item per cycle (a byte or a flush) while the
// job queue has room and gives every byte back unchanged, tagged raw,
// rejected sync, packet, flushed remainder or truncation marker, with
// first/last marks on accepted packets and last_of_run on the final result
// of each item. An item causes zero to four results, moved one per cycle
// by the output register unless the output stalls: a plain byte gives one,
// an accepted header or a rejected header with rescanned bytes up to four.
// A four-entry job queue between the front state machine and the back
// sequencer absorbs those bursts; in_ch.ready falls only in reset or when
// that queue is full. Results pass through the job queue and the output
// register. The packet limit register resets to 4096; the user writes it
// through cfg_ch only while the block is idle, which it does not check.
// ----------------------------------------------------------------------------
module tlv_packet_framer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tlvf_in_if.sink    in_ch,
  tlvf_out_if.source out_ch,
  tlvf_cfg_if.sink   cfg_ch
);
  import tlvf_pkg::*;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic pop;
  job_t head;
  logic q_empty;

  // framer state machine: classifies each item and builds its job
  tlvf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  // decouples the stream side from the result side
  tlvf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // one result per cycle into the output register unless the output stalls
  tlvf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* src/tlvf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvf_front: framer state machine
// accepts stream items, tracks header and body, pushes a job for each result-bearing item
// ----------------------------------------------------------------------------
module tlvf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tlvf_in_if.sink            in_ch,
  tlvf_cfg_if.sink           cfg_ch,
  input  wire logic          q_full,
  output logic               push,
  output tlvf_pkg::job_t     job
);
  import tlvf_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  hold_r [3];
  logic [7:0]  hold_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] max_r;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] rem_dec;
  logic [15:0] len;
  logic        type_ok;
  logic        size_ok;
  logic        hdr_ok;
  scan_t       scan;
  logic [2:0]  n_res;

  // nothing is taken while in reset
  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = rst_n && !q_full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.in_byte;

  assign rem_dec = rem_r - 16'd1;
  assign len     = {hold_r[2], b};
  assign type_ok = (hold_r[1] <= TYPE_LOW_MAX) || (hold_r[1] >= TYPE_HIGH_MIN);
  assign size_ok = ({1'b0, len} + HDR_BYTES) <= max_r;
  assign hdr_ok  = type_ok && size_ok;
  assign scan    = tlvf_rescan({b, hold_r[2], hold_r[1]});

  // next state
  always_comb begin
    mode_nxt = mode_r;
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    if (accept) begin
      if (in_ch.operation == OP_FLUSH) begin
        mode_nxt = MODE_HUNT;
        cnt_nxt  = 2'd0;
        rem_nxt  = 16'd0;
      end else begin
        unique case (mode_r)
          MODE_BODY: begin
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) mode_nxt = MODE_HUNT;
          end
          MODE_HEADER: begin
            if (cnt_r == 2'd3) begin
              if (hdr_ok) begin
                cnt_nxt  = 2'd0;
                rem_nxt  = len;
                mode_nxt = (len == 16'd0) ? MODE_HUNT : MODE_BODY;
              end else begin
                mode_nxt = scan.hdr ? MODE_HEADER : MODE_HUNT;
                cnt_nxt  = scan.hold_cnt;
                for (int i = 0; i < 3; i++) hold_nxt[i] = scan.hold[i];
              end
            end else begin
              hold_nxt[cnt_r] = b;
              cnt_nxt         = cnt_r + 2'd1;
            end
          end
          default: begin
            if (b == SYNC_BYTE) begin
              mode_nxt    = MODE_HEADER;
              hold_nxt[0] = b;
              cnt_nxt     = 2'd1;
            end else begin
              mode_nxt = MODE_HUNT;
            end
          end
        endcase
      end
    end
  end

  // results of the item at the port
  always_comb begin
    job   = '0;
    n_res = 3'd0;
    if (in_ch.operation == OP_FLUSH) begin
      unique case (mode_r)
        MODE_HEADER: begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(cnt_r)) begin
              job.res[n_res[1:0]] = mk_res(hold_r[i], KIND_FLUSHED, 1'b0, 1'b0);
              n_res = n_res + 3'd1;
            end
          end
        end
        MODE_BODY: begin
          job.res[0] = mk_res(8'd0, KIND_TRUNC, 1'b0, 1'b0);
          n_res      = 3'd1;
        end
        default: n_res = 3'd0;
      endcase
    end else begin
      unique case (mode_r)
        MODE_BODY: begin
          job.res[0] = mk_res(b, KIND_PACKET, 1'b0, rem_dec == 16'd0);
          n_res      = 3'd1;
        end
        MODE_HEADER: begin
          if (cnt_r == 2'd3) begin
            if (hdr_ok) begin
              job.res[0] = mk_res(hold_r[0], KIND_PACKET, 1'b1, 1'b0);
              job.res[1] = mk_res(hold_r[1], KIND_PACKET, 1'b0, 1'b0);
              job.res[2] = mk_res(hold_r[2], KIND_PACKET, 1'b0, 1'b0);
              job.res[3] = mk_res(b, KIND_PACKET, 1'b0, len == 16'd0);
              n_res      = 3'd4;
            end else begin
              job.res[0] = mk_res(hold_r[0], KIND_REJECT, 1'b0, 1'b0);
              n_res      = 3'd1;
              for (int i = 0; i < 3; i++) begin
                if (i < int'(scan.n_raw)) begin
                  job.res[n_res[1:0]] = mk_res((i == 0) ? hold_r[1] :
                                               (i == 1) ? hold_r[2] : b,
                                               KIND_RAW, 1'b0, 1'b0);
                  n_res = n_res + 3'd1;
                end
              end
            end
          end
        end
        default: begin
          if (b != SYNC_BYTE) begin
            job.res[0] = mk_res(b, KIND_RAW, 1'b0, 1'b0);
            n_res      = 3'd1;
          end
        end
      endcase
    end
    job.last_idx = 2'(n_res - 3'd1);
  end

  assign push = accept && (n_res != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      cnt_r  <= 2'd0;
      rem_r  <= 16'd0;
      max_r  <= MAX_PKT_RESET;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      if (cfg_ch.valid) max_r <= cfg_ch.max_packet_bytes;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule
`default_nettype wire

/* src/tlvf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvf_queue: job queue
// short first-in first-out store of jobs between front and back
// ----------------------------------------------------------------------------
module tlvf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlvf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output tlvf_pkg::job_t      head,
  output logic                empty
);
  import tlvf_pkg::*;

  job_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_r, rd_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule
`default_nettype wire

/* src/tlvf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvf_back: result sequencer
// walks the results of the head job into the output register unless the output stalls, one per cycle
// ----------------------------------------------------------------------------
module tlvf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlvf_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  tlvf_out_if.source          out_ch
);
  import tlvf_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  res_t       res_r;
  logic       lor_r;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!valid_r || out_ch.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= head.res[idx_r];
      lor_r <= at_last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.out_byte     = res_r.data;
  assign out_ch.byte_kind    = res_r.kind;
  assign out_ch.packet_first = res_r.first;
  assign out_ch.packet_last  = res_r.last;
  assign out_ch.last_of_run  = lor_r;

endmodule
`default_nettype wire
